// ----- src/longest_nonoverlap_repeat_unit_assert.svh -----
// Assertion macros shared by the longest non-overlapping repeat block.
// No dependencies; included by modules that carry concurrent checks.
`ifndef LONGEST_NONOVERLAP_REPEAT_UNIT_ASSERT_SVH
`define LONGEST_NONOVERLAP_REPEAT_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define LNR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: ante -> cons");
`define LNR_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: ante => cons");
`else
`define LNR_ASSERT_IMP(label, clk, rstn, ante, cons)
`define LNR_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- src/lnr_pkg.sv -----
// Shared constants and types for the longest non-overlapping repeat block.
// No dependencies.
`timescale 1ns / 1ps
package lnr_pkg;
    localparam int MAX_LEN = 256;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // one classified input byte
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       keep;   // byte fits in the text store
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;
endpackage

// ----- src/longest_nonoverlap_repeat_unit.sv -----
// Longest non-overlapping repeated substring: bytes stream in, one request per cycle
// while the input queue has room; the search is a diagonal scan reading two store
// bytes per cycle for every start pair.
// Throughput: one string at a time; bytes queue (4 deep) while a search runs.
// Reset (aresetn low, synchronous) clears control state; the text store is not cleared.
// Top level; depends on lnr_pkg, lnr_front, lnr_fifo and lnr_back.
`timescale 1ns / 1ps
module longest_nonoverlap_repeat_unit
    import lnr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [0] found, [8:1] start_pos, [16:9] repeat_len
);
    q_status_t q_status;
    q_entry_t  q_wdata, q_rdata;
    logic      q_push, q_pop;

    lnr_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    lnr_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .status  (q_status)
    );

    lnr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );
endmodule

// ----- src/lnr_front.sv -----
// Front end: accepts bytes, tracks string length, marks bytes past the store.
// Depends on lnr_pkg.
`timescale 1ns / 1ps
module lnr_front
    import lnr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  q_status_t  q_status,
    output logic       q_push,
    output q_entry_t   q_wdata
);
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             keep;

    assign s_axis_tready = !q_status.full;
    assign q_push        = s_axis_tvalid && s_axis_tready;
    assign keep          = (cnt_reg < CNT_W'(MAX_LEN));

    assign q_wdata.ch   = s_axis_tdata;
    assign q_wdata.last = s_axis_tlast;
    assign q_wdata.keep = keep;

    always_comb begin
        cnt_next = cnt_reg;
        if (q_push) begin
            if (s_axis_tlast) begin
                cnt_next = '0;
            end else if (keep) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ----- src/lnr_fifo.sv -----
// Short request queue between front end and search engine.
// Depends on lnr_pkg.
`timescale 1ns / 1ps
module lnr_fifo
    import lnr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  q_entry_t  wdata,
    input  logic      pop,
    output q_entry_t  rdata,
    output q_status_t status
);
    q_entry_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = slot_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end
endmodule

// ----- src/lnr_back.sv -----
// Search engine: text store, diagonal match-run scan, result register.
// Depends on lnr_pkg and longest_nonoverlap_repeat_unit_assert.svh.
`timescale 1ns / 1ps
`include "longest_nonoverlap_repeat_unit_assert.svh"
module lnr_back
    import lnr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  q_status_t   q_status,
    input  q_entry_t    q_rdata,
    output logic        q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata
);
    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [7:0]        text_mem [MAX_LEN];

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  wr_cnt_reg, wr_cnt_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [ADDR_W-1:0] d_reg, d_next;
    logic [ADDR_W-1:0] p_reg, p_next;
    logic              diag_start_reg, diag_start_next;

    // scan pipeline: issue -> read data -> run length -> compare
    logic              s1_valid_reg, s1_first_reg;
    logic [ADDR_W-1:0] s1_p_reg, s1_d_reg;
    logic [7:0]        rd_a_reg, rd_b_reg;
    logic              s2_valid_reg;
    logic [ADDR_W-1:0] s2_p_reg, s2_d_reg;
    logic [CNT_W-1:0]  run_len_reg, run_len_next;

    logic [CNT_W-1:0]  best_len_reg, best_len_next;
    logic [ADDR_W-1:0] best_start_reg, best_start_next;

    logic              m_valid_reg, m_valid_next;
    logic [23:0]       m_data_reg, m_data_next;

    logic              issue, cand, out_free, found;
    logic [CNT_W-1:0]  n_new, last_d, next_p;
    logic [ADDR_W-1:0] q_addr;

    assign q_pop    = (state_reg == ST_LOAD) && !q_status.empty;
    assign issue    = (state_reg == ST_SCAN);
    assign q_addr   = p_reg + d_reg;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign n_new    = wr_cnt_reg + CNT_W'(q_rdata.keep);
    assign last_d   = n_reg - CNT_W'(1);
    // first start of the next diagonal: n - 2 - d
    assign next_p   = n_reg - CNT_W'(2) - CNT_W'(d_reg);
    assign found    = (best_len_reg != '0);

    // run of matches going backward along the diagonal = common prefix length
    always_comb begin
        run_len_next = run_len_reg;
        if (s1_valid_reg) begin
            if (rd_a_reg != rd_b_reg) begin
                run_len_next = '0;
            end else if (s1_first_reg) begin
                run_len_next = CNT_W'(1);
            end else begin
                run_len_next = run_len_reg + CNT_W'(1);
            end
        end
    end

    // non-overlap check, longest wins, ties to earliest start
    assign cand = s2_valid_reg && (run_len_reg != '0)
               && (run_len_reg <= CNT_W'(s2_d_reg))
               && ((run_len_reg > best_len_reg)
                   || ((run_len_reg == best_len_reg) && (s2_p_reg < best_start_reg)));

    always_comb begin
        state_next      = state_reg;
        wr_cnt_next     = wr_cnt_reg;
        n_next          = n_reg;
        d_next          = d_reg;
        p_next          = p_reg;
        diag_start_next = diag_start_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        if (cand) begin
            best_len_next   = run_len_reg;
            best_start_next = s2_p_reg;
        end
        case (state_reg)
            ST_LOAD: begin
                if (q_pop) begin
                    if (q_rdata.last) begin
                        wr_cnt_next     = '0;
                        n_next          = n_new;
                        d_next          = ADDR_W'(1);
                        p_next          = ADDR_W'(n_new - CNT_W'(2));
                        diag_start_next = 1'b1;
                        best_len_next   = '0;
                        best_start_next = '0;
                        state_next      = (n_new >= CNT_W'(2)) ? ST_SCAN : ST_DONE;
                    end else begin
                        wr_cnt_next = n_new;
                    end
                end
            end
            ST_SCAN: begin
                diag_start_next = 1'b0;
                if (p_reg == '0) begin
                    if (CNT_W'(d_reg) == last_d) begin
                        state_next = ST_DRAIN;
                    end else begin
                        p_next          = ADDR_W'(next_p);
                        d_next          = d_reg + ADDR_W'(1);
                        diag_start_next = 1'b1;
                    end
                end else begin
                    p_next = p_reg - ADDR_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!s1_valid_reg && !s2_valid_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, 8'(best_len_reg), 8'(best_start_reg), found};
                    state_next   = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_rdata.keep) begin
            text_mem[wr_cnt_reg[ADDR_W-1:0]] <= q_rdata.ch;
        end
        if (issue) begin
            rd_a_reg <= text_mem[p_reg];
            rd_b_reg <= text_mem[q_addr];
        end
    end

    always_ff @(posedge aclk) begin
        s1_first_reg <= diag_start_reg;
        s1_p_reg     <= p_reg;
        s1_d_reg     <= d_reg;
        s2_p_reg     <= s1_p_reg;
        s2_d_reg     <= s1_d_reg;
        run_len_reg  <= run_len_next;
        m_data_reg   <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            wr_cnt_reg     <= '0;
            n_reg          <= '0;
            d_reg          <= '0;
            p_reg          <= '0;
            diag_start_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            best_len_reg   <= '0;
            best_start_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wr_cnt_reg     <= wr_cnt_next;
            n_reg          <= n_next;
            d_reg          <= d_next;
            p_reg          <= p_next;
            diag_start_reg <= diag_start_next;
            s1_valid_reg   <= issue;
            s2_valid_reg   <= s1_valid_reg;
            best_len_reg   <= best_len_next;
            best_start_reg <= best_start_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    `LNR_ASSERT_IMP(a_scan_in_range, aclk, aresetn, state_reg == ST_SCAN, (CNT_W'(p_reg) + CNT_W'(d_reg)) < n_reg)
    `LNR_ASSERT_IMP(a_found_len, aclk, aresetn, m_valid_reg, m_data_reg[0] == (m_data_reg[16:9] != 8'd0))
    `LNR_ASSERT_NXT(a_scan_exit, aclk, aresetn, state_reg == ST_SCAN, state_reg == ST_SCAN || state_reg == ST_DRAIN)
endmodule

// ----- tb/longest_nonoverlap_repeat_unit_test.sv -----
// Self-checking bench for longest_nonoverlap_repeat_unit: streams strings byte by byte
// and checks every search result against a behavioral longest-repeat predictor or a typed row's result.
// Depends on lnr_pkg and the longest_nonoverlap_repeat_unit RTL.
`timescale 1ns / 1ps
module longest_nonoverlap_repeat_unit_test;
    import lnr_pkg::MAX_LEN;

    localparam int ITEM_TARGET   = 800;
    localparam int DIRECTED_ROWS = 24;
    localparam int HOLD_CYCLES   = 600;
    localparam int DRAIN_CYCLES  = 64;

    // found sits in bit 0, matching the result tdata layout
    typedef struct packed {
        logic [7:0] repeat_len;
        logic [7:0] start_pos;
        logic       found;
    } repeat_result_t;

    // typed = 1: the result of this string is written into the row
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic       found;
        logic [7:0] start_pos;
        logic [7:0] repeat_len;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    logic [7:0]     text_copy [MAX_LEN];
    int             held_bytes;
    repeat_result_t pending_results [$];
    repeat_result_t fixed_result;
    bit             fixed_pending;
    int             results_seen;
    int             failures;
    int             items_sent;
    bit             tx_idle;
    bit             rx_idle;
    bit             rx_hold;
    bit             rx_hold_request;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // one-byte string
        {8'h41, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0},
        // zero bytes compare like any other
        {8'h00, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'h00, 1'b1, 1'b1, 1'b1, 8'd0, 8'd1},
        // extremes, no repeat
        {8'h01, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'hff, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0},
        // overlapping matches are skipped, not clamped
        {8'h61, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'h61, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'h61, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'h61, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0},
        // exact abutting repeat
        {8'h61, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'h62, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'h61, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'h62, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0},
        // several length-one ties, earliest start wins
        {8'h78, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'h79, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'h78, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'h7a, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'h79, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'h7a, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0},
        // high-bit bytes
        {8'hff, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'h80, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'hff, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'h80, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        {8'h7f, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0}
    };

    longest_nonoverlap_repeat_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] char_in
        .s_axis_tlast  (s_axis_tlast),   // last_char
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [0] found, [8:1] start_pos, [16:9] repeat_len
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // brute-force scan over all start pairs of the first n stored bytes
    function automatic repeat_result_t find_longest_repeat(input int n);
        repeat_result_t res;
        int best_len;
        int best_start;
        int k;
        best_len   = 0;
        best_start = 0;
        for (int p = 0; p < n; p++) begin
            for (int q = p + 1; q < n; q++) begin
                k = 0;
                while (q + k < n && text_copy[p + k] == text_copy[q + k])
                    k++;
                if (k <= q - p && k > best_len) begin
                    best_len   = k;
                    best_start = p;
                end
            end
        end
        res.found      = (best_len > 0);
        res.start_pos  = (best_len > 0) ? best_start[7:0] : 8'd0;
        res.repeat_len = best_len[7:0];
        return res;
    endfunction

    task automatic log_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    // results are checked before the byte of the same edge is absorbed
    always @(posedge aclk) begin : scoreboard
        repeat_result_t got;
        repeat_result_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[16:0];
                results_seen++;
                if (pending_results.size() == 0) begin
                    log_failure($sformatf("unexpected result found=%0b start=%0d len=%0d",
                        got.found, got.start_pos, got.repeat_len));
                end else begin
                    want = pending_results.pop_front();
                    if (got.found !== want.found || got.start_pos !== want.start_pos ||
                        got.repeat_len !== want.repeat_len)
                        log_failure($sformatf(
                            "result %0d: want found=%0b start=%0d len=%0d, got found=%0b start=%0d len=%0d",
                            results_seen, want.found, want.start_pos, want.repeat_len,
                            got.found, got.start_pos, got.repeat_len));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                // bytes beyond the store are dropped, but a dropped last still ends the string
                if (held_bytes < MAX_LEN) begin
                    text_copy[held_bytes] = s_axis_tdata;
                    held_bytes++;
                end
                if (s_axis_tlast) begin
                    want = find_longest_repeat(held_bytes);
                    if (fixed_pending) begin
                        want          = fixed_result;
                        fixed_pending = 1'b0;
                    end
                    pending_results.push_back(want);
                    held_bytes = 0;
                end
            end
        end
    end

    // result side: random gaps per result while rx_idle is set, plus the one long hold from output_hold
    initial begin : result_sink
        int stall_left;
        int taken_before;
        stall_left    = 0;
        taken_before  = 0;
        m_axis_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (results_seen != taken_before) begin
                taken_before = results_seen;
                stall_left   = rx_idle ? $urandom_range(0, 3) : 0;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= !rx_hold;
            end
        end
    end

    initial begin : output_hold
        rx_hold = 1'b0;
        wait (rx_hold_request);
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] ch, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // small alphabets make repeats likely
    task automatic send_string(input int len, input int alphabet);
        logic [7:0] palette [4];
        for (int i = 0; i < 4; i++)
            palette[i] = $urandom_range(0, 255);
        for (int i = 0; i < len; i++)
            send_byte(palette[$urandom_range(0, alphabet - 1)], i == len - 1);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    initial begin : stimulus
        int len;
        aresetn         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = 8'h00;
        s_axis_tlast    = 1'b0;
        held_bytes      = 0;
        fixed_pending   = 1'b0;
        fixed_result    = '0;
        results_seen    = 0;
        failures        = 0;
        items_sent      = 0;
        tx_idle         = 1'b1;
        rx_idle         = 1'b1;
        rx_hold_request = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].typed) begin
                fixed_result.found      = directed_rows[r].found;
                fixed_result.start_pos  = directed_rows[r].start_pos;
                fixed_result.repeat_len = directed_rows[r].repeat_len;
                fixed_pending           = 1'b1;
            end
            send_byte(directed_rows[r].ch, directed_rows[r].last);
        end
        wait_all_results();

        // result side stalls while short strings keep coming: input queue must back up
        tx_idle         = 1'b0;
        rx_hold_request = 1'b1;
        for (int s = 0; s < 10; s++)
            send_string($urandom_range(1, 6), $urandom_range(1, 4));
        wait_all_results();
        tx_idle = 1'b1;

        // overlong run of one byte: longest repeat is half the store
        send_string(MAX_LEN + 2, 1);
        wait_all_results();
        send_string(MAX_LEN, 2);
        wait_all_results();

        for (int s = 0; items_sent < ITEM_TARGET; s++) begin
            if (s % 10 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            send_string(len, $urandom_range(1, 4));
            if (s % 25 == 24)
                wait_all_results();
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+src
src/lnr_pkg.sv
src/lnr_front.sv
src/lnr_fifo.sv
src/lnr_back.sv
src/longest_nonoverlap_repeat_unit.sv
tb/longest_nonoverlap_repeat_unit_test.sv
